[sv/mdpa_pkg.sv]
// Shared types and constants for the modular dot-product accumulator.
// Depends on nothing; imported by every module of the block.
package mdpa_pkg;
    localparam int unsigned FIELD_BITS     = 64;
    localparam int unsigned WORD_BITS_DEF  = 64;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 64'd1;

    // Front-to-back queue entry: operand pair and last mark
    typedef struct packed {
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        logic                  last;
    } t_term;
endpackage

[sv/modular_dot_product_accumulator.sv]
// Top level: modular dot-product accumulator.
// Flow: a last item passes through the queue, the multiply, the accumulate add,
// 3*WORD_BITS reduction steps and the output load before its result is valid.
// The back end takes a new item only after the accumulate add of the one before;
// a last item holds it through reduction and output; the queue takes items meanwhile.
// Reset: synchronous active-low, clears accumulator, queue and state; modulus resets to 1.
module modular_dot_product_accumulator #(
    parameter int unsigned WORD_BITS   = mdpa_pkg::WORD_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = mdpa_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mdpa_pkg::FIELD_BITS-1:0] i_a_value,
    input  logic [mdpa_pkg::FIELD_BITS-1:0] i_b_value,
    input  logic                            i_last_term,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mdpa_pkg::FIELD_BITS-1:0] o_product_mod,
    input  logic                            i_cfg_we,
    input  logic [mdpa_pkg::FIELD_BITS-1:0] i_cfg_wdata
);
    import mdpa_pkg::*;
    logic [FIELD_BITS-1:0] r_modulus;
    logic q_valid, q_ready;
    t_term q_term;

    // Hold the modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_modulus <= MODULUS_RESET;
        else if (i_cfg_we) r_modulus <= i_cfg_wdata;
    end

    mdpa_front #(.WORD_BITS(WORD_BITS), .DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_a_value, .i_b_value, .i_last_term,
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_term(q_term)
    );

    mdpa_back #(.WORD_BITS(WORD_BITS)) u_back (
        .i_clk, .i_rst_n, .i_modulus(r_modulus), .i_q_valid(q_valid), .o_q_ready(q_ready),
        .i_q_term(q_term), .o_valid, .i_ready, .o_product_mod
    );
endmodule

[sv/mdpa_front.sv]
// Front part: accepts items, masks operands to the word width, and queues them.
// Depends on mdpa_pkg.
module mdpa_front #(
    parameter int unsigned WORD_BITS = mdpa_pkg::WORD_BITS_DEF,
    parameter int unsigned DEPTH     = mdpa_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mdpa_pkg::FIELD_BITS-1:0] i_a_value,
    input  logic [mdpa_pkg::FIELD_BITS-1:0] i_b_value,
    input  logic                          i_last_term,
    output logic                          o_q_valid,
    input  logic                          i_q_ready,
    output mdpa_pkg::t_term               o_q_term
);
    import mdpa_pkg::*;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [FIELD_BITS-1:0] MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - WORD_BITS);

    t_term r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_ready   = (r_cnt < (AW+1)'(DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_term  = r_mem[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    // Store the masked item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{a: i_a_value & MASK, b: i_b_value & MASK, last: i_last_term};
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_cnt == $past(r_cnt) + 1'b1) else $error("count slip");
endmodule

[sv/mdpa_back.sv]
// Back part: multiply-accumulate into a three-word sum and bit-serial reduction.
// Depends on mdpa_pkg.
module mdpa_back #(
    parameter int unsigned WORD_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [mdpa_pkg::FIELD_BITS-1:0] i_modulus,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  mdpa_pkg::t_term                 i_q_term,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mdpa_pkg::FIELD_BITS-1:0] o_product_mod
);
    import mdpa_pkg::*;
    localparam int unsigned ACC_BITS = 3 * WORD_BITS;
    localparam int unsigned HB = 32;
    localparam int unsigned CW = $clog2(ACC_BITS);
    localparam logic [1:0] S_MAC = 2'd0, S_ADD = 2'd1, S_RED = 2'd2, S_OUT = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [ACC_BITS-1:0] r_acc;
    logic [ACC_BITS-1:0] r_sh;
    logic [63:0]         r_pll, r_plh, r_phl, r_phh;
    logic                r_last;
    logic [CW-1:0]       r_cnt;
    logic [64:0]         r_rem;
    logic [64:0]         dbl;
    logic [127:0]        prod;
    logic                out_free;
    logic [FIELD_BITS-1:0] r_res;
    logic                r_ovalid;

    assign out_free  = !r_ovalid || i_ready;
    assign o_q_ready = (r_state == S_MAC);
    assign o_valid   = r_ovalid;
    assign o_product_mod = r_res;

    // Sum the four partial products
    assign prod = {64'd0, r_pll} + ({64'd0, r_plh} << HB) + ({64'd0, r_phl} << HB)
                + ({r_phh, 64'd0});
    // Shift one accumulator bit into the remainder
    assign dbl = {r_rem[63:0], r_sh[ACC_BITS-1]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_MAC: if (i_q_valid) n_state = S_ADD;
            S_ADD: n_state = r_last ? S_RED : S_MAC;
            S_RED: if (r_cnt == CW'(ACC_BITS-1)) n_state = S_OUT;
            S_OUT: if (out_free) n_state = S_MAC;
            default: n_state = S_MAC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // Split multiply: four 32x32 partial products
        if (r_state == S_MAC && i_q_valid) begin
            r_pll  <= i_q_term.a[31:0]  * i_q_term.b[31:0];
            r_plh  <= i_q_term.a[31:0]  * i_q_term.b[63:32];
            r_phl  <= i_q_term.a[63:32] * i_q_term.b[31:0];
            r_phh  <= i_q_term.a[63:32] * i_q_term.b[63:32];
            r_last <= i_q_term.last;
        end
        if (r_state == S_ADD) begin
            r_sh  <= r_acc + ACC_BITS'(prod[2*WORD_BITS-1:0]);
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (r_state == S_RED) begin
            r_sh  <= r_sh << 1;
            r_cnt <= r_cnt + 1'b1;
            r_rem <= (dbl >= {1'b0, i_modulus}) ? dbl - {1'b0, i_modulus} : dbl;
        end
        if (r_state == S_OUT && out_free) begin
            r_res <= (i_modulus == '0) ? '0 : r_rem[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_MAC;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ADD)
                r_acc <= r_last ? '0 : r_acc + ACC_BITS'(prod[2*WORD_BITS-1:0]);
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (i_ready)                 r_ovalid <= 1'b0;
        end
    end

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_modulus != '0) |-> r_rem < {1'b0, i_modulus})
        else $error("remainder not reduced");
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_last) |=> r_acc == '0) else $error("acc not cleared");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> o_valid) else $error("result lost");
endmodule
